// ----- design/smc_pkg.sv -----
package smc_pkg;

    // Build defaults for the top-level parameters
    localparam int SMC_MAX_WORD_BITS = 16;
    localparam int SMC_DIVIDER_BITS  = 8;

    // Fixed field widths
    localparam int DATA_W      = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DIVIDER  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLARITY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WORD_LEN = 3'd3;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_RDATA  = 2'd2,
        OP_STATUS = 2'd3
    } t_op;

    // Classified item as it travels from front to engine
    typedef struct packed {
        logic              is_tick;
        logic              is_write;
        logic              is_rdata;
        logic              is_status;
        logic [DATA_W-1:0] wdata;
        logic              miso;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic              sck;
        logic              mosi;
        logic [DATA_W-1:0] rdata;
        logic              done;
        logic              collision;
        logic              overrun;
        logic              busy;
    } t_result;

endpackage

// ----- design/spi_master_controller_top.sv -----
// Channel | Direction | Handshake                    | Payload
// in      | input     | i_in_valid / o_in_ready      | i_operation, i_write_data, i_miso_level
// out     | output    | o_out_valid / i_out_ready    | o_sck_level .. o_busy_res
// cfg     | input     | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
// One item per clock sustained while the output is not stalled; each item gives one result.
// The rate is set by the engine: one item per cycle to the serial state, unless stalled.
// A two-entry queue between decode and engine absorbs a stalled output register.
// Synchronous active-low reset; clears flags, pointers and the transfer state.
// When the output stalls, the queue fills and o_in_ready drops once it is full.
module spi_master_controller_top
    import smc_pkg::*;
#(
    parameter int MAX_WORD_BITS = SMC_MAX_WORD_BITS,
    parameter int DIVIDER_BITS  = SMC_DIVIDER_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_operation,
    input  logic [DATA_W-1:0]      i_write_data,
    input  logic                   i_miso_level,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_sck_level,
    output logic                   o_mosi_level,
    output logic [DATA_W-1:0]      o_read_data,
    output logic                   o_transfer_done,
    output logic                   o_write_collision,
    output logic                   o_read_overrun,
    output logic                   o_busy_res
);

    t_cmd    dec_cmd, q_cmd;
    t_result res;
    logic    q_full, q_nempty, q_pop;

    assign o_in_ready = !q_full;

    smc_front u_front (
        .i_operation  (i_operation),
        .i_write_data (i_write_data),
        .i_miso_level (i_miso_level),
        .o_cmd        (dec_cmd)
    );

    smc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_in_valid && !q_full),
        .i_data   (dec_cmd),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_nempty (q_nempty),
        .o_data   (q_cmd)
    );

    smc_engine #(
        .MAX_WORD_BITS (MAX_WORD_BITS),
        .DIVIDER_BITS  (DIVIDER_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_nempty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (res)
    );

    assign o_sck_level       = res.sck;
    assign o_mosi_level      = res.mosi;
    assign o_read_data       = res.rdata;
    assign o_transfer_done   = res.done;
    assign o_write_collision = res.collision;
    assign o_read_overrun    = res.overrun;
    assign o_busy_res        = res.busy;

endmodule

// ----- design/smc_front.sv -----
module smc_front
    import smc_pkg::*;
(
    input  logic [1:0]        i_operation,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic              i_miso_level,
    output t_cmd              o_cmd
);

    // Decode the operation; unused payload is zeroed so the engine sees clean fields
    always_comb begin
        o_cmd = '0;
        case (t_op'(i_operation))
            OP_TICK: begin
                o_cmd.is_tick = 1'b1;
                o_cmd.miso    = i_miso_level;
            end
            OP_WRITE: begin
                o_cmd.is_write = 1'b1;
                o_cmd.wdata    = i_write_data;
            end
            OP_RDATA:  o_cmd.is_rdata  = 1'b1;
            OP_STATUS: o_cmd.is_status = 1'b1;
            default:   o_cmd = '0;
        endcase
    end

endmodule

// ----- design/smc_queue.sv -----
module smc_queue
    import smc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_nempty,
    output t_cmd o_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_full   = (r_count == CW'(QUEUE_DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_data   = r_mem[r_rptr];

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= wrap_inc(r_wptr);
            if (i_pop)  r_rptr <= wrap_inc(r_rptr);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !(i_push && !i_pop))
        else $error("queue written while full");

endmodule

// ----- design/smc_engine.sv -----
module smc_engine
    import smc_pkg::*;
#(
    parameter int MAX_WORD_BITS = SMC_MAX_WORD_BITS,
    parameter int DIVIDER_BITS  = SMC_DIVIDER_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_cmd_valid,
    input  t_cmd                   i_cmd,
    output logic                   o_cmd_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_result                o_result
);

    localparam int MW = MAX_WORD_BITS;
    localparam int BW = $clog2(MAX_WORD_BITS + 1);
    localparam int IW = $clog2(MAX_WORD_BITS);
    localparam int DW = DIVIDER_BITS;

    // Configuration
    logic [CFG_DATA_W-1:0] r_div;
    logic                  r_pha, r_pol;
    logic [4:0]            r_wlen;

    // Transfer state
    logic [MW-1:0]     r_tx, n_tx;
    logic [DATA_W-1:0] r_rx, n_rx, r_rword, n_rword;
    logic [BW-1:0]     r_bits, n_bits;
    logic [DW-1:0]     r_cnt, n_cnt;
    logic r_clk, n_clk, r_mosi, n_mosi, r_running, n_running;
    logic r_done, n_done, r_coll, n_coll, r_ovr, n_ovr, r_seen, n_seen;

    // Output register
    t_result r_out;
    logic    r_out_valid;

    logic              pop;
    logic [15:0]       div_ext;
    logic [DW-1:0]     div_m, half, cnt_inc;
    logic [5:0]        wlen_sat;
    logic [BW-1:0]     eff_len;
    logic [DATA_W-1:0] rx_shift, rdata;
    logic              fin, leading;

    assign pop         = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_pop   = pop;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    function automatic logic tx_pick(input logic [MW-1:0] v, input logic [BW-1:0] cnt);
        logic [BW-1:0] m1;
        m1 = cnt - BW'(1);
        return v[m1[IW-1:0]];
    endfunction

    // Half period: divider made even and at least 8, then halved
    always_comb begin
        div_ext = {8'b0, r_div};
        div_m   = div_ext[DW-1:0] & ~DW'(1);
        if (div_m < DW'(8)) div_m = DW'(8);
        half = div_m >> 1;
    end

    // Word length saturated to 8 .. MAX_WORD_BITS
    always_comb begin
        wlen_sat = {1'b0, r_wlen};
        if (wlen_sat < 6'd8) wlen_sat = 6'd8;
        if (wlen_sat > 6'(MAX_WORD_BITS)) wlen_sat = 6'(MAX_WORD_BITS);
        eff_len = BW'(wlen_sat);
    end

    assign rx_shift = {r_rx[DATA_W-2:0], i_cmd.miso};
    assign cnt_inc  = r_cnt + DW'(1);

    // Next state for one item
    always_comb begin
        n_tx = r_tx;  n_rx = r_rx;  n_rword = r_rword;  n_bits = r_bits;
        n_cnt = r_cnt;  n_clk = r_clk;  n_mosi = r_mosi;  n_running = r_running;
        n_done = r_done;  n_coll = r_coll;  n_ovr = r_ovr;  n_seen = r_seen;
        rdata   = '0;
        fin     = 1'b0;
        leading = 1'b0;
        if (pop) begin
            if (i_cmd.is_tick) begin
                if (!r_running) begin
                    n_clk = r_pol;
                end else if (cnt_inc < half) begin
                    n_cnt = cnt_inc;
                end else begin
                    // SCK edge
                    n_cnt   = '0;
                    n_clk   = ~r_clk;
                    leading = (~r_clk) != r_pol;
                    if (r_bits == '0) begin
                        fin = 1'b1;
                    end else if (leading) begin
                        if (r_pha) n_mosi = tx_pick(r_tx, r_bits);
                        else       n_rx   = rx_shift;
                    end else begin
                        if (r_pha) n_rx = rx_shift;
                        n_bits = r_bits - BW'(1);
                        if (n_bits == '0)  fin    = 1'b1;
                        else if (!r_pha)   n_mosi = tx_pick(r_tx, n_bits);
                    end
                end
            end else if (i_cmd.is_write) begin
                if (r_running) begin
                    n_coll = 1'b1;
                end else begin
                    if (r_seen) begin
                        n_done = 1'b0;  n_coll = 1'b0;  n_ovr = 1'b0;  n_seen = 1'b0;
                    end
                    n_tx      = MW'(i_cmd.wdata);
                    n_rx      = '0;
                    n_bits    = eff_len;
                    n_cnt     = '0;
                    n_clk     = r_pol;
                    n_running = 1'b1;
                    n_mosi    = tx_pick(MW'(i_cmd.wdata), eff_len);
                end
            end else if (i_cmd.is_rdata) begin
                rdata = r_rword;
                if (r_seen) begin
                    n_done = 1'b0;  n_coll = 1'b0;  n_ovr = 1'b0;  n_seen = 1'b0;
                end
            end else if (i_cmd.is_status) begin
                if (r_done || r_coll || r_ovr) n_seen = 1'b1;
            end
            // end of word
            if (fin) begin
                n_running = 1'b0;
                n_rword   = n_rx;
                if (r_done) n_ovr = 1'b1;
                n_done = 1'b1;
            end
        end
        // idle SCK follows a polarity change
        if (i_cfg_we && (i_cfg_index == CFG_POLARITY) && !r_running) begin
            n_clk = i_cfg_data[0];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div  <= CFG_DATA_W'(8);
            r_pha  <= 1'b0;
            r_pol  <= 1'b0;
            r_wlen <= 5'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIVIDER:  r_div  <= i_cfg_data;
                CFG_PHASE:    r_pha  <= i_cfg_data[0];
                CFG_POLARITY: r_pol  <= i_cfg_data[0];
                CFG_WORD_LEN: r_wlen <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Transfer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx <= '0;  r_rx <= '0;  r_rword <= '0;  r_bits <= '0;  r_cnt <= '0;
            r_clk <= 1'b0;  r_mosi <= 1'b0;  r_running <= 1'b0;
            r_done <= 1'b0;  r_coll <= 1'b0;  r_ovr <= 1'b0;  r_seen <= 1'b0;
        end else begin
            r_tx <= n_tx;  r_rx <= n_rx;  r_rword <= n_rword;  r_bits <= n_bits;
            r_cnt <= n_cnt;  r_clk <= n_clk;  r_mosi <= n_mosi;  r_running <= n_running;
            r_done <= n_done;  r_coll <= n_coll;  r_ovr <= n_ovr;  r_seen <= n_seen;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.sck       <= n_clk;
            r_out.mosi      <= n_mosi;
            r_out.rdata     <= rdata;
            r_out.done      <= n_done;
            r_out.collision <= n_coll;
            r_out.overrun   <= n_ovr;
            r_out.busy      <= n_running;
        end
    end

    a_busy_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_bits != '0))
        else $error("transfer running with no bits left");

    a_done_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> !r_running && $past(r_running))
        else $error("done flag rose without a finished word");

    a_collision_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_coll) |-> $past(pop && i_cmd.is_write && r_running))
        else $error("collision flag without a write during a transfer");

endmodule

// ----- sim/spi_tb_pkg.sv -----
`timescale 1ns / 100ps
package spi_tb_pkg;
    import smc_pkg::*;

    // Tracks the serial engine item by item and holds the line levels and
    // flags that each accepted item should produce.
    class spi_line_board;
        // register copies
        logic [7:0]  divider;
        logic        phase_sel;
        logic        polarity;
        logic [4:0]  word_len;

        // engine state
        logic [15:0] tx_shift;
        logic [15:0] rx_shift;
        logic [15:0] rx_word;
        logic [4:0]  bits_left;
        logic [15:0] half_count;
        logic        sck;
        logic        mosi;
        logic        running;
        logic        done;
        logic        collision;
        logic        overrun;
        logic        armed;

        t_result     expected_lines[$];
        int unsigned mismatches;

        function new();
            divider    = 8'd8;
            phase_sel  = 1'b0;
            polarity   = 1'b0;
            word_len   = 5'd8;
            tx_shift   = '0;
            rx_shift   = '0;
            rx_word    = '0;
            bits_left  = '0;
            half_count = '0;
            sck        = 1'b0;
            mosi       = 1'b0;
            running    = 1'b0;
            done       = 1'b0;
            collision  = 1'b0;
            overrun    = 1'b0;
            armed      = 1'b0;
            mismatches = 0;
        endfunction

        // ticks per SCK half period: divider with bit 0 dropped and a floor of 8, halved
        function int unsigned half_period();
            logic [7:0] d;
            d = divider & 8'hFE;
            if (d < 8'd8) d = 8'd8;
            return d >> 1;
        endfunction

        // bits per word, clamped to 8 .. max
        function logic [4:0] word_bits();
            logic [4:0] w;
            w = word_len;
            if (w < 5'd8) w = 5'd8;
            if (w > SMC_MAX_WORD_BITS) w = 5'(SMC_MAX_WORD_BITS);
            return w;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DIVIDER:  divider   = data;
                CFG_PHASE:    phase_sel = data[0];
                CFG_POLARITY: begin
                    polarity = data[0];
                    if (!running) sck = polarity;
                end
                CFG_WORD_LEN: word_len  = data[4:0];
                default: ;
            endcase
        endfunction

        function void end_word();
            running = 1'b0;
            rx_word = rx_shift;
            if (done) overrun = 1'b1;
            done = 1'b1;
        endfunction

        // one tick of the serial time base
        function void serial_tick(logic miso);
            logic leading;
            if (!running) begin
                sck = polarity;
                return;
            end
            half_count++;
            if (half_count < half_period()) return;
            half_count = '0;
            sck = ~sck;
            leading = (sck != polarity);
            if (bits_left == 0) begin
                end_word();
                return;
            end
            if (leading) begin
                if (phase_sel) mosi = tx_shift[bits_left - 5'd1];
                else rx_shift = {rx_shift[14:0], miso};
            end else begin
                if (phase_sel) rx_shift = {rx_shift[14:0], miso};
                bits_left--;
                if (bits_left == 0) end_word();
                else if (!phase_sel) mosi = tx_shift[bits_left - 5'd1];
            end
        endfunction

        // data access after an armed status read clears the flags
        function void clear_on_access();
            if (armed) begin
                done      = 1'b0;
                collision = 1'b0;
                overrun   = 1'b0;
                armed     = 1'b0;
            end
        endfunction

        function void note_item(t_op op, logic [15:0] wdata, logic miso);
            t_result r;
            r.rdata = '0;
            case (op)
                OP_TICK: serial_tick(miso);
                OP_WRITE: begin
                    if (running) begin
                        collision = 1'b1;
                    end else begin
                        clear_on_access();
                        tx_shift   = wdata;
                        rx_shift   = '0;
                        bits_left  = word_bits();
                        half_count = '0;
                        sck        = polarity;
                        running    = 1'b1;
                        mosi       = tx_shift[bits_left - 5'd1];
                    end
                end
                OP_RDATA: begin
                    r.rdata = rx_word;
                    clear_on_access();
                end
                default: begin
                    if (done || collision || overrun) armed = 1'b1;
                end
            endcase
            r.sck       = sck;
            r.mosi      = mosi;
            r.done      = done;
            r.collision = collision;
            r.overrun   = overrun;
            r.busy      = running;
            expected_lines.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            logic    bad;
            if (expected_lines.size() == 0) begin
                if (mismatches < 10)
                    $display("result with no item outstanding: data=%h", got.rdata);
                mismatches++;
                return;
            end
            want = expected_lines.pop_front();
            bad = (got.sck !== want.sck) || (got.mosi !== want.mosi)
                || (got.rdata !== want.rdata) || (got.done !== want.done)
                || (got.collision !== want.collision) || (got.overrun !== want.overrun)
                || (got.busy !== want.busy);
            if (bad) begin
                if (mismatches < 10) begin
                    $display("mismatch: exp sck=%b mosi=%b data=%h done=%b wcol=%b ovr=%b busy=%b",
                             want.sck, want.mosi, want.rdata, want.done, want.collision,
                             want.overrun, want.busy);
                    $display("          got sck=%b mosi=%b data=%h done=%b wcol=%b ovr=%b busy=%b",
                             got.sck, got.mosi, got.rdata, got.done, got.collision,
                             got.overrun, got.busy);
                end
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_lines.size();
        endfunction

        function logic busy();
            return running;
        endfunction
    endclass

endpackage

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
module tb;
    import smc_pkg::*;
    import spi_tb_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;  // unmapped index
    localparam int STALL_CYCLES = 200;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    t_op                    in_op;
    logic [DATA_W-1:0]      in_wdata;
    logic                   in_miso;
    logic                   out_valid;
    logic                   out_ready;
    logic                   sck_line;
    logic                   mosi_line;
    logic [DATA_W-1:0]      rd_word;
    logic                   done_flag;
    logic                   wcol_flag;
    logic                   ovr_flag;
    logic                   busy_flag;

    spi_line_board lines = new();

    bit          src_steady;
    bit          sink_steady;
    bit          stall_request;
    int          stall_left;
    int unsigned items_sent;

    spi_master_controller_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_operation      (in_op),
        .i_write_data     (in_wdata),
        .i_miso_level     (in_miso),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_sck_level      (sck_line),
        .o_mosi_level     (mosi_line),
        .o_read_data      (rd_word),
        .o_transfer_done  (done_flag),
        .o_write_collision(wcol_flag),
        .o_read_overrun   (ovr_flag),
        .o_busy_res       (busy_flag)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (stall_request) begin
                stall_request = 1'b0;
                stall_left    = STALL_CYCLES - 1;
                out_ready    <= 1'b0;
            end else begin
                out_ready <= sink_steady || ($urandom_range(99) >= 36);
            end
        end
    end

    // watch both channels at the clock edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (in_valid && in_ready)
                    lines.note_item(in_op, in_wdata, in_miso);
                if (out_valid && out_ready)
                    lines.check_result({sck_line, mosi_line, rd_word, done_flag,
                                        wcol_flag, ovr_flag, busy_flag});
            end
        end
    end

    function automatic logic [15:0] rand_word();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one item, entered and left at a falling edge
    task automatic push_item(input t_op op, input logic [15:0] wd, input logic miso);
        while (!src_steady && $urandom_range(99) < 36) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_wdata <= wd;
        in_miso  <= miso;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // start a word and tick it to the end, with occasional other accesses
    task automatic send_word(input logic [15:0] wd, input int unsigned extra_pct);
        push_item(OP_WRITE, wd, 1'($urandom));
        while (lines.busy()) begin
            if ($urandom_range(99) < extra_pct)
                push_item(t_op'($urandom_range(3, 1)), rand_word(), 1'($urandom));
            else
                push_item(OP_TICK, 16'($urandom), 1'($urandom));
        end
    endtask

    task automatic random_phase(input int unsigned quota, input bit end_running);
        int unsigned start;
        int unsigned pick;
        start = items_sent;
        while (items_sent - start < quota) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_word(rand_word(), 4);
                pick = $urandom_range(9);
                if (pick <= 5) begin
                    push_item(OP_STATUS, rand_word(), 1'($urandom));
                    push_item(OP_RDATA, rand_word(), 1'($urandom));
                end else if (pick == 6) begin
                    push_item(OP_RDATA, rand_word(), 1'($urandom));
                end else if (pick == 7) begin
                    push_item(OP_STATUS, rand_word(), 1'($urandom));
                end else if (pick == 8) begin
                    push_item(OP_STATUS, rand_word(), 1'($urandom));
                    push_item(OP_STATUS, rand_word(), 1'($urandom));
                    push_item(OP_RDATA, rand_word(), 1'($urandom));
                end
                // otherwise done stays set and the next word overruns
            end else begin
                push_item(t_op'($urandom_range(3)), rand_word(), 1'($urandom));
            end
        end
        // leave a word running across the next register change
        if (end_running) push_item(OP_WRITE, rand_word(), 1'b0);
    endtask

    // wait until every outstanding result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (lines.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // register write; write enable is left high for back-to-back writes
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        lines.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [7:0] div, input logic pha, input logic pol,
                             input logic [7:0] wl);
        cfg_write(CFG_DIVIDER, div);
        cfg_write(CFG_PHASE, {7'($urandom), pha});
        cfg_write(CFG_POLARITY, {7'($urandom), pol});
        cfg_write(CFG_WORD_LEN, wl);
        cfg_we <= 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_op         = OP_TICK;
        in_wdata      = '0;
        in_miso       = 1'b0;
        src_steady    = 1'b0;
        sink_steady   = 1'b0;
        stall_request = 1'b0;
        items_sent    = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: accesses with no flags, idle tick
        push_item(OP_STATUS, 16'h0000, 1'b0);
        push_item(OP_RDATA, 16'hFFFF, 1'b1);
        push_item(OP_TICK, 16'hFFFF, 1'b1);
        // all-ones word, write collision partway
        push_item(OP_WRITE, 16'hFFFF, 1'b0);
        push_item(OP_WRITE, 16'h1234, 1'b1);
        send_word(16'h0000, 0);
        // word finished: a data read before a status read keeps done; after one it clears the flags
        push_item(OP_RDATA, 16'h0000, 1'b0);
        push_item(OP_STATUS, 16'h0000, 1'b0);
        push_item(OP_STATUS, 16'h0000, 1'b0);
        push_item(OP_RDATA, 16'h0000, 1'b0);
        push_item(OP_STATUS, 16'h0000, 1'b0);
        // write after an armed status read clears the flags
        send_word(16'h8001, 0);
        push_item(OP_STATUS, 16'h0000, 1'b0);
        send_word(16'h7FFE, 0);
        push_item(OP_RDATA, 16'h0000, 1'b0);
        drain();

        // receiver holds off while the sender keeps offering
        src_steady    = 1'b1;
        stall_request = 1'b1;
        cfg_write(CFG_SPARE, 8'h5A);
        configure(8'd8, 1'b0, 1'b0, 8'd8);
        random_phase(120, 1'b0);
        drain();
        src_steady = 1'b0;

        // odd divider, longest word
        configure(8'd9, 1'b1, 1'b0, 8'd16);
        random_phase(120, 1'b1);
        drain();

        // divider below the floor
        configure(8'd3, 1'b0, 1'b1, 8'd12);
        random_phase(120, 1'b0);
        drain();

        // no idling on either side; word length above range
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        configure(8'd10, 1'b1, 1'b1, 8'd31);
        random_phase(120, 1'b1);
        drain();
        src_steady  = 1'b0;
        sink_steady = 1'b0;

        // zero divider, word length below range
        configure(8'd0, 1'b0, 1'b1, 8'd5);
        random_phase(120, 1'b0);
        drain();

        // slow clock: a single word
        configure(8'd45, 1'b0, 1'b1, 8'd8);
        send_word(rand_word(), 1);
        push_item(OP_STATUS, 16'h0000, 1'b0);
        push_item(OP_RDATA, 16'h0000, 1'b0);
        drain();

        configure(8'd12, 1'b1, 1'b0, 8'd0);
        random_phase(120, 1'b0);
        drain();
        repeat (10) @(negedge i_clk);

        if (lines.mismatches == 0 && lines.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/smc_pkg.sv
design/smc_front.sv
design/smc_queue.sv
design/smc_engine.sv
design/spi_master_controller_top.sv
sim/spi_tb_pkg.sv
sim/tb.sv
